/* rtl/esc_iter_pkg.sv */
`default_nettype none

package esc_iter_pkg;

    // Fixed-point format: Q4.FRAC_BITS, one sign bit
    localparam int PIXEL_BITS = 10;
    localparam int FRAC_BITS  = 28;
    localparam int VAL_W      = FRAC_BITS + 4;
    // Truncated product of two values, signed
    localparam int PROD_W     = 2 * VAL_W - FRAC_BITS;
    // Headroom for sums of products before saturation
    localparam int SUM_W      = PROD_W + 2;
    localparam int CNT_W      = 8;
    localparam int CFG_W      = 32;
    localparam int MAG_W      = 31;
    localparam int CFG_IDX_W  = 3;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'sd1 <<< (VAL_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO =
        SUM_W'(-(64'sd1 <<< (VAL_W - 1)));

    // Escape thresholds on the squared magnitude
    localparam logic signed [SUM_W-1:0] ESC_FOUR    = SUM_W'(64'sd4 <<< FRAC_BITS);
    localparam logic signed [SUM_W-1:0] ESC_SIXTEEN = SUM_W'(64'sd16 <<< FRAC_BITS);

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_x;
        logic [PIXEL_BITS-1:0] pixel_y;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] iter_count;
        logic             reached_limit;
    } out_item_t;

    // One point in flight around the cell ring
    typedef struct packed {
        logic                    valid;
        logic                    done;
        logic                    fresh;
        logic [CNT_W-1:0]        cnt;
        logic signed [VAL_W-1:0] zx;
        logic signed [VAL_W-1:0] zy;
    } esc_tok_t;

    // Per-item controls shared by all cells
    typedef struct packed {
        logic                    julia;
        logic                    ship;
        logic [CNT_W-1:0]        limit;
        logic signed [VAL_W-1:0] cx;
        logic signed [VAL_W-1:0] cy;
    } esc_ctl_t;

    // Clamp a wide sum into the value range
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[VAL_W-1:0];
        end
        if (v < SAT_LO) begin
            return SAT_LO[VAL_W-1:0];
        end
        return v[VAL_W-1:0];
    endfunction

    // Fixed-point product, truncated toward zero, not saturated
    function automatic logic signed [PROD_W-1:0] qmul(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
        logic [VAL_W-1:0]   ma;
        logic [VAL_W-1:0]   mb;
        logic [2*VAL_W-1:0] full;
        logic [PROD_W-1:0]  mag;
        ma   = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
        mb   = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);
        full = ma * mb;
        mag  = PROD_W'(full >> FRAC_BITS);
        return (a[VAL_W-1] ^ b[VAL_W-1]) ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

/* rtl/esc_iter_map.sv */
`default_nettype none

// Maps one pixel index to the plane: ((pixel / 100 + offset) * inv_mag)
// Five register stages, one coordinate.
module esc_iter_map (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [esc_iter_pkg::PIXEL_BITS-1:0]        pixel,
    input  logic signed [esc_iter_pkg::CFG_W-1:0]      offset,
    input  logic [esc_iter_pkg::MAG_W-1:0]             inv_mag,
    input  logic                                       negate,
    output logic                                       done,
    output logic signed [esc_iter_pkg::VAL_W-1:0]      coord
);

    localparam int PIXEL_BITS = esc_iter_pkg::PIXEL_BITS;
    localparam int FRAC_BITS  = esc_iter_pkg::FRAC_BITS;
    localparam int VAL_W      = esc_iter_pkg::VAL_W;
    localparam int SUM_W      = esc_iter_pkg::SUM_W;
    localparam int MAG_W      = esc_iter_pkg::MAG_W;
    localparam int LAT        = 5;
    localparam int DIV_K      = 100;
    localparam int NUMER_W    = PIXEL_BITS + FRAC_BITS;
    localparam int RECIP_W    = NUMER_W - 6;
    localparam int P1_W       = PIXEL_BITS + RECIP_W;
    localparam int P4_W       = VAL_W + MAG_W;
    localparam int SHIFT_W    = P4_W - FRAC_BITS;
    // Reciprocal of the divisor, scaled so the estimate is at most one low
    localparam logic [63:0]        RECIP_FULL = (64'd1 << NUMER_W) / DIV_K;
    localparam logic [RECIP_W-1:0] RECIP      = RECIP_FULL[RECIP_W-1:0];

    logic [LAT-1:0]           vld_reg;
    logic [P1_W-1:0]          prod1_reg;
    logic [PIXEL_BITS-1:0]    pix1_reg;
    logic [RECIP_W-1:0]       q2_reg;
    logic [RECIP_W-1:0]       q2_next;
    logic signed [VAL_W-1:0]  s3_reg;
    logic signed [VAL_W-1:0]  s3_next;
    logic [P4_W-1:0]          prod4_reg;
    logic                     neg4_reg;
    logic signed [VAL_W-1:0]  coord_reg;
    logic signed [VAL_W-1:0]  coord_next;

    logic [RECIP_W-1:0]       q0;
    logic [NUMER_W-1:0]       numer;
    logic [NUMER_W-1:0]       rem;
    logic signed [SUM_W-1:0]  q_ext;
    logic signed [SUM_W-1:0]  off_ext;
    logic signed [VAL_W-1:0]  s_pos;
    logic [VAL_W-1:0]         s_mag;
    logic [SHIFT_W-1:0]       shifted;
    logic signed [SUM_W-1:0]  sh_ext;

    // Stage valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start};
        end
    end

    // Quotient estimate, then one compare-and-correct step
    always_comb
    begin
        q0      = RECIP_W'(prod1_reg >> PIXEL_BITS);
        numer   = {pix1_reg, {FRAC_BITS{1'b0}}};
        rem     = numer - NUMER_W'(q0) * NUMER_W'(DIV_K);
        q2_next = q0 + RECIP_W'(rem >= NUMER_W'(DIV_K));
    end

    // Offset add, optional negation
    always_comb
    begin
        q_ext   = $signed(SUM_W'(q2_reg));
        off_ext = SUM_W'(offset);
        s_pos   = esc_iter_pkg::sat_val(q_ext + off_ext);
        s3_next = negate ? esc_iter_pkg::sat_val(-SUM_W'(s_pos)) : s_pos;
    end

    assign s_mag = s3_reg[VAL_W-1] ? VAL_W'(-s3_reg) : VAL_W'(s3_reg);

    // Scale by inverse magnification, truncate toward zero
    always_comb
    begin
        shifted    = SHIFT_W'(prod4_reg >> FRAC_BITS);
        sh_ext     = $signed(SUM_W'(shifted));
        coord_next = esc_iter_pkg::sat_val(neg4_reg ? -sh_ext : sh_ext);
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod1_reg <= pixel * RECIP;
        pix1_reg  <= pixel;
        q2_reg    <= q2_next;
        s3_reg    <= s3_next;
        prod4_reg <= s_mag * inv_mag;
        neg4_reg  <= s3_reg[VAL_W-1];
        coord_reg <= coord_next;
    end

    assign done  = vld_reg[LAT-1];
    assign coord = coord_reg;

endmodule

`default_nettype wire

/* rtl/esc_iter_cell.sv */
`default_nettype none

// One escape-loop step: products of z, then decide and update z.
// Two register stages; a finished point passes through unchanged.
module esc_iter_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  esc_iter_pkg::esc_ctl_t ctl,
    input  esc_iter_pkg::esc_tok_t tok_in,
    output esc_iter_pkg::esc_tok_t tok_out
);

    localparam int VAL_W  = esc_iter_pkg::VAL_W;
    localparam int PROD_W = esc_iter_pkg::PROD_W;
    localparam int SUM_W  = esc_iter_pkg::SUM_W;

    esc_iter_pkg::esc_tok_t   a_tok_reg;
    esc_iter_pkg::esc_tok_t   tok_out_reg;
    esc_iter_pkg::esc_tok_t   tok_out_next;
    logic signed [PROD_W-1:0] x2_reg;
    logic signed [PROD_W-1:0] y2_reg;
    logic signed [PROD_W-1:0] p_reg;

    logic signed [VAL_W-1:0]  cx;
    logic signed [VAL_W-1:0]  cy;
    logic signed [PROD_W-1:0] p_eff;
    logic signed [SUM_W-1:0]  sq_sum;
    logic signed [SUM_W-1:0]  re_sum;
    logic signed [SUM_W-1:0]  im_sum;
    logic                     escaped;
    logic                     lim_hit;

    // Stage 1: token control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tok_reg <= '0;
        end
        else
        begin
            a_tok_reg <= tok_in;
        end
    end

    // Stage 1: the three products of z
    always_ff @(posedge clk)
    begin
        x2_reg <= esc_iter_pkg::qmul(tok_in.zx, tok_in.zx);
        y2_reg <= esc_iter_pkg::qmul(tok_in.zy, tok_in.zy);
        p_reg  <= esc_iter_pkg::qmul(tok_in.zx, tok_in.zy);
    end

    assign cx = ctl.cx;
    assign cy = ctl.cy;

    // Stage 2: escape test and z update
    always_comb
    begin
        p_eff   = (ctl.ship && (p_reg < 0)) ? -p_reg : p_reg;
        sq_sum  = SUM_W'(x2_reg) + SUM_W'(y2_reg);
        re_sum  = SUM_W'(x2_reg) - SUM_W'(y2_reg) + SUM_W'(cx);
        im_sum  = (SUM_W'(p_eff) <<< 1) + SUM_W'(cy);
        lim_hit = (a_tok_reg.cnt >= ctl.limit);
        if (ctl.julia)
        begin
            escaped = !a_tok_reg.fresh && (sq_sum > esc_iter_pkg::ESC_FOUR);
        end
        else
        begin
            escaped = (sq_sum >= esc_iter_pkg::ESC_SIXTEEN);
        end

        tok_out_next = a_tok_reg;
        if (a_tok_reg.valid && !a_tok_reg.done)
        begin
            if (ctl.julia && escaped)
            begin
                // Julia stops at the step that produced this z
                tok_out_next.done = 1'b1;
                tok_out_next.cnt  = a_tok_reg.cnt - 1'b1;
            end
            else if (escaped || lim_hit)
            begin
                tok_out_next.done = 1'b1;
            end
            else
            begin
                tok_out_next.zx    = esc_iter_pkg::sat_val(re_sum);
                tok_out_next.zy    = esc_iter_pkg::sat_val(im_sum);
                tok_out_next.cnt   = a_tok_reg.cnt + 1'b1;
                tok_out_next.fresh = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_out_reg <= '0;
        end
        else
        begin
            tok_out_reg <= tok_out_next;
        end
    end

    assign tok_out = tok_out_reg;

endmodule

`default_nettype wire

/* rtl/escape_time_fractal_iterator_core.sv */
`default_nettype none

// Channel  | Dir | Handshake           | Payload
// ---------+-----+---------------------+---------------------------------
// in       | in  | in_valid / in_stall | in_data  (pixel_x, pixel_y)
// out      | out | out_valid/out_stall | out_data (iter_count, reached_limit)
// cfg      | in  | cfg_wen             | cfg_index, cfg_data
//
// One point at a time. A point first passes through coordinate mapping, then
// through a multiply stage and an update stage per escape-loop step as it moves
// through the cell ring.
// Reset sets the registers to their defaults and empties the ring.
// in_stall is high from an input transfer until its result is captured.
// A finished point keeps circling the ring while the output register is full.
module escape_time_fractal_iterator_core #(
    parameter int NUM_CELLS = 2
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  esc_iter_pkg::in_item_t                   in_data,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output esc_iter_pkg::out_item_t                  out_data,
    input  logic                                     cfg_wen,
    input  logic [esc_iter_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [esc_iter_pkg::CFG_W-1:0]           cfg_data
);

    localparam int VAL_W     = esc_iter_pkg::VAL_W;
    localparam int SUM_W     = esc_iter_pkg::SUM_W;
    localparam int CNT_W     = esc_iter_pkg::CNT_W;
    localparam int CFG_W     = esc_iter_pkg::CFG_W;
    localparam int MAG_W     = esc_iter_pkg::MAG_W;
    localparam int CFG_IDX_W = esc_iter_pkg::CFG_IDX_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_MAG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd6;

    // Fractal modes; the unused code runs as Mandelbrot
    localparam logic [1:0] MODE_JULIA = 2'd1;
    localparam logic [1:0] MODE_SHIP  = 2'd2;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAP  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]                state_reg;
    logic [1:0]                state_next;

    logic [1:0]                mode_reg;
    logic signed [CFG_W-1:0]   x_offset_reg;
    logic signed [CFG_W-1:0]   y_offset_reg;
    logic [MAG_W-1:0]          inv_mag_reg;
    logic signed [CFG_W-1:0]   julia_re_reg;
    logic signed [CFG_W-1:0]   julia_im_reg;
    logic [CNT_W-1:0]          max_iter_reg;

    logic signed [VAL_W-1:0]   cx_reg;
    logic signed [VAL_W-1:0]   cy_reg;
    logic signed [VAL_W-1:0]   cx_next;
    logic signed [VAL_W-1:0]   cy_next;

    logic                      out_valid_reg;
    esc_iter_pkg::out_item_t   out_data_reg;
    esc_iter_pkg::out_item_t   out_data_next;

    logic                      julia;
    logic                      in_xfer;
    logic                      map_x_done;
    logic                      map_y_done;
    logic                      map_done;
    logic signed [VAL_W-1:0]   map_x;
    logic signed [VAL_W-1:0]   map_y;
    logic                      out_free;
    logic                      capture;

    esc_iter_pkg::esc_ctl_t    ctl;
    esc_iter_pkg::esc_tok_t    load_tok;
    esc_iter_pkg::esc_tok_t    ring_in  [NUM_CELLS];
    esc_iter_pkg::esc_tok_t    ring_out [NUM_CELLS];
    esc_iter_pkg::esc_tok_t    ring_end;
    logic [NUM_CELLS-1:0]      ring_vld;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 2'd0;
            x_offset_reg <= 32'shD000_0000;
            y_offset_reg <= 32'shE000_0000;
            inv_mag_reg  <= 31'h1000_0000;
            julia_re_reg <= '0;
            julia_im_reg <= '0;
            max_iter_reg <= 8'd25;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_data[1:0];
                REG_X_OFFSET: x_offset_reg <= $signed(cfg_data);
                REG_Y_OFFSET: y_offset_reg <= $signed(cfg_data);
                REG_INV_MAG:  inv_mag_reg  <= cfg_data[MAG_W-1:0];
                REG_JULIA_RE: julia_re_reg <= $signed(cfg_data);
                REG_JULIA_IM: julia_im_reg <= $signed(cfg_data);
                REG_MAX_ITER: max_iter_reg <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    assign julia   = (mode_reg == MODE_JULIA);
    assign in_xfer = in_valid && !in_stall;

    // Coordinate mapping, one unit per axis
    esc_iter_map u_map_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_xfer),
        .pixel   (in_data.pixel_x),
        .offset  (x_offset_reg),
        .inv_mag (inv_mag_reg),
        .negate  (1'b0),
        .done    (map_x_done),
        .coord   (map_x)
    );

    esc_iter_map u_map_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_xfer),
        .pixel   (in_data.pixel_y),
        .offset  (y_offset_reg),
        .inv_mag (inv_mag_reg),
        .negate  (julia),
        .done    (map_y_done),
        .coord   (map_y)
    );

    assign map_done = map_x_done && map_y_done;

    // Start values: Julia starts from the pixel, the others from zero
    always_comb
    begin
        load_tok       = '0;
        load_tok.valid = 1'b1;
        load_tok.fresh = 1'b1;
        load_tok.cnt   = CNT_W'(1);
        if (julia)
        begin
            load_tok.zx = map_x;
            load_tok.zy = map_y;
            cx_next     = esc_iter_pkg::sat_val(SUM_W'(julia_re_reg));
            cy_next     = esc_iter_pkg::sat_val(SUM_W'(julia_im_reg));
        end
        else
        begin
            cx_next = map_x;
            cy_next = map_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_done)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
    end

    always_comb
    begin
        ctl       = '0;
        ctl.julia = julia;
        ctl.ship  = (mode_reg == MODE_SHIP);
        ctl.limit = max_iter_reg;
        ctl.cx    = cx_reg;
        ctl.cy    = cy_reg;
    end

    // Cell ring
    assign ring_end = ring_out[NUM_CELLS-1];
    assign out_free = !out_valid_reg || !out_stall;
    assign capture  = (state_reg == ST_RUN) && ring_end.valid && ring_end.done && out_free;

    always_comb
    begin
        if (map_done)
        begin
            ring_in[0] = load_tok;
        end
        else if (capture)
        begin
            ring_in[0] = '0;
        end
        else
        begin
            ring_in[0] = ring_end;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++)
        begin : g_cell
            esc_iter_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .tok_in  (ring_in[g]),
                .tok_out (ring_out[g])
            );
            assign ring_vld[g] = ring_out[g].valid;
        end
        for (g = 1; g < NUM_CELLS; g++)
        begin : g_link
            assign ring_in[g] = ring_out[g-1];
        end
    endgenerate

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                if (map_done)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (capture)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // Output register
    always_comb
    begin
        out_data_next.iter_count    = ring_end.cnt;
        out_data_next.reached_limit = (ring_end.cnt == max_iter_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (capture)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // Only one point travels the ring at a time
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(ring_vld) <= 1)
        else $error("more than one point in the cell ring");

    // An idle block holds nothing in the ring
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (ring_vld == '0))
        else $error("ring not empty while idle");

    // Mapping finishes only while the sequencer waits for it
    a_map_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        (map_x_done || map_y_done) |-> (state_reg == ST_MAP))
        else $error("mapping result outside the map phase");

    // A new result comes only from a running point
    a_out_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RUN))
        else $error("result appeared without a running point");
`endif

endmodule

`default_nettype wire
